// ===== rtl/sobel_gradient_window_filter_defines.svh =====
// assertion macros for the sobel gradient window filter
`ifndef SOBEL_GRADIENT_WINDOW_FILTER_DEFINES_SVH
`define SOBEL_GRADIENT_WINDOW_FILTER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SGWF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SGWF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SGWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sgwf_pkg.sv =====
// types, register codes and kernel tables of the sobel gradient window filter
package sgwf_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int SUM_W   = 16;
    localparam int MIN_SIZE = 3;

    typedef logic [PIX_W-1:0]         t_pixel;
    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [CFG_W-1:0]         t_cfg_data;
    typedef logic [IDX_W-1:0]         t_cfg_index;
    typedef logic signed [4:0]        t_coef;
    typedef logic signed [13:0]       t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // register indexes
    localparam t_cfg_index REG_IMAGE_WIDTH      = 2'd0;
    localparam t_cfg_index REG_IMAGE_HEIGHT     = 2'd1;
    localparam t_cfg_index REG_KERNEL_FIVE      = 2'd2;
    localparam t_cfg_index REG_KERNEL_DIRECTION = 2'd3;

    localparam t_cfg_data RST_IMAGE_WIDTH  = 11'd750;
    localparam t_cfg_data RST_IMAGE_HEIGHT = 11'd500;

    // per-request bookkeeping carried down the pipe
    typedef struct packed {
        logic   has_res;
        t_coord col;
        t_coord row;
        logic   last;
    } t_meta;

    localparam t_coef K3_HOR [9] = '{-5'sd1, 5'sd0, 5'sd1,
                                     -5'sd2, 5'sd0, 5'sd2,
                                     -5'sd1, 5'sd0, 5'sd1};
    localparam t_coef K3_VER [9] = '{-5'sd1, -5'sd2, -5'sd1,
                                      5'sd0,  5'sd0,  5'sd0,
                                      5'sd1,  5'sd2,  5'sd1};
    localparam t_coef K5_HOR [25] = '{
        -5'sd1, -5'sd2, 5'sd0, 5'sd2, 5'sd1,
        -5'sd2, -5'sd4, 5'sd0, 5'sd4, 5'sd2,
        -5'sd4, -5'sd8, 5'sd0, 5'sd8, 5'sd4,
        -5'sd2, -5'sd4, 5'sd0, 5'sd4, 5'sd2,
        -5'sd1, -5'sd2, 5'sd0, 5'sd2, 5'sd1};
    localparam t_coef K5_VER [25] = '{
        -5'sd1, -5'sd2, -5'sd4, -5'sd2, -5'sd1,
        -5'sd2, -5'sd4, -5'sd8, -5'sd4, -5'sd2,
         5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,
         5'sd2,  5'sd4,  5'sd8,  5'sd4,  5'sd2,
         5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1};

    // coefficient of one 5x5 window tap; the 3x3 kernel sits in the lower right
    function automatic t_coef kern_coef(input logic five, input logic dir,
                                        input int unsigned row, input int unsigned col);
        t_coef c;
        c = '0;
        if (five) begin
            c = dir ? K5_VER[row*5+col] : K5_HOR[row*5+col];
        end else if (row >= 2 && col >= 2) begin
            c = dir ? K3_VER[(row-2)*3+(col-2)] : K3_HOR[(row-2)*3+(col-2)];
        end
        return c;
    endfunction

endpackage

// ===== rtl/sobel_gradient_window_filter.sv =====
// sobel gradient filter, 3x3 magnitude or 5x5 signed, over a raster pixel stream
// path: a result reaches o_valid through stage 1, window, row sum, kernel sum and output registers
// throughput: one pixel per cycle while o_stall is low; each pixel does one read of the line memory
//   when taken and one write-back of the same entry when stage 1 moves on
// reset: counters, window, pipe valids and registers (750, 500, 0, 0) cleared at once;
//   the line memory is not cleared, no clearing pass, pixels are taken right away
`include "sobel_gradient_window_filter_defines.svh"

module sobel_gradient_window_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sgwf_pkg::t_pixel     i_pixel,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output sgwf_pkg::t_pixel     o_gradient_pixel,
    output sgwf_pkg::t_coord     o_center_col,
    output sgwf_pkg::t_coord     o_center_row,
    output logic                 o_last_of_frame,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  sgwf_pkg::t_cfg_index i_cfg_index,
    input  sgwf_pkg::t_cfg_data  i_cfg_data
);
    import sgwf_pkg::*;

    // column and row counter widths, and the widths used to clamp the size registers
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int MEM_W = 4 * PIX_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_cfg_data r_image_width;
    t_cfg_data r_image_height;
    logic      r_kernel_five;
    logic      r_kernel_direction;
    logic      cfg_we;
    logic      cfg_known;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        case (i_cfg_index)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
            REG_KERNEL_FIVE, REG_KERNEL_DIRECTION: cfg_known = 1'b1;
            default:                               cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width      <= RST_IMAGE_WIDTH;
            r_image_height     <= RST_IMAGE_HEIGHT;
            r_kernel_five      <= 1'b0;
            r_kernel_direction <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:      r_image_width      <= i_cfg_data;
                REG_IMAGE_HEIGHT:     r_image_height     <= i_cfg_data;
                REG_KERNEL_FIVE:      r_kernel_five      <= i_cfg_data[0];
                REG_KERNEL_DIRECTION: r_kernel_direction <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective frame size, clamped to 3..MAX, kept as last index
    logic [WCW-1:0] w_ext, w_clamped;
    logic [HCW-1:0] h_ext, h_clamped;
    logic [CW-1:0]  w_last;
    logic [RW-1:0]  h_last;

    always_comb begin
        w_ext = WCW'(r_image_width);
        h_ext = HCW'(r_image_height);
        if (w_ext < WCW'(MIN_SIZE))       w_clamped = WCW'(MIN_SIZE);
        else if (w_ext > WCW'(MAX_WIDTH)) w_clamped = WCW'(MAX_WIDTH);
        else                              w_clamped = w_ext;
        if (h_ext < HCW'(MIN_SIZE))        h_clamped = HCW'(MIN_SIZE);
        else if (h_ext > HCW'(MAX_HEIGHT)) h_clamped = HCW'(MAX_HEIGHT);
        else                               h_clamped = h_ext;
        w_last = CW'(w_clamped - WCW'(1));
        h_last = RW'(h_clamped - HCW'(1));
    end

    // ------------------------------------------------------------------
    // pipe control: each stage moves when the next one is free or moving
    // ------------------------------------------------------------------
    logic  r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    t_meta r_s1_meta, r_s2_meta, r_s3_meta, r_s4_meta;
    logic  out_free, s4_move, s4_free, s3_move, s3_free;
    logic  s2_move, s2_free, s1_move, s1_free, in_take;

    assign out_free = !r_out_valid || !i_stall;
    // a request with no result leaves stage 4 without touching the output
    assign s4_move  = r_s4_valid && (out_free || !r_s4_meta.has_res);
    assign s4_free  = !r_s4_valid || s4_move;
    assign s3_move  = r_s3_valid && s4_free;
    assign s3_free  = !r_s3_valid || s3_move;
    assign s2_move  = r_s2_valid && s3_free;
    assign s2_free  = !r_s2_valid || s2_move;
    assign s1_move  = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s1_move;
    assign o_stall  = !s1_free;
    assign in_take  = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // position counters and per-pixel bookkeeping
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    t_meta         in_meta;
    logic [CW-1:0] col_off;
    logic [RW-1:0] row_off;

    always_comb begin
        // centre sits one (3x3) or two (5x5) pixels back from the newest pixel
        col_off = r_kernel_five ? CW'(2) : CW'(1);
        row_off = r_kernel_five ? RW'(2) : RW'(1);
        in_meta.has_res = r_kernel_five ? (r_col >= CW'(4) && r_row >= RW'(4))
                                        : (r_col >= CW'(2) && r_row >= RW'(2));
        in_meta.col  = t_coord'(r_col - col_off);
        in_meta.row  = t_coord'(r_row - row_off);
        in_meta.last = (r_col == w_last) && (r_row == h_last);

        // raster walk; the frame wraps after its last pixel
        if (r_col == w_last) begin
            n_col = '0;
            n_row = (r_row == h_last) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_we && cfg_known) begin
            // any register write restarts the frame
            r_col <= '0;
            r_row <= '0;
        end else if (in_take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // line memory: one entry per column holds the four previous rows,
    // byte 0 = row r-1 ... byte 3 = row r-4; read on take, written back
    // shifted when stage 1 moves on. the same column comes back only a full row
    // later, so read and write-back never meet on one entry.
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    logic [MEM_W-1:0] r_mem_q;
    t_pixel           r_s1_px;
    logic [CW-1:0]    r_s1_col;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mem_q <= line_mem[r_col];
        end
        if (s1_move) begin
            line_mem[r_s1_col] <= {r_mem_q[3*PIX_W-1:0], r_s1_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_px   <= i_pixel;
            r_s1_col  <= r_col;
            r_s1_meta <= in_meta;
        end
    end

    // ------------------------------------------------------------------
    // 5x5 window: each request shifts in a new column (oldest row on top)
    // ------------------------------------------------------------------
    t_pixel r_window [25];
    t_pixel column [5];

    always_comb begin
        column[0] = r_mem_q[4*PIX_W-1:3*PIX_W];
        column[1] = r_mem_q[3*PIX_W-1:2*PIX_W];
        column[2] = r_mem_q[2*PIX_W-1:PIX_W];
        column[3] = r_mem_q[PIX_W-1:0];
        column[4] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 25; k++) begin
                r_window[k] <= '0;
            end
        end else if (s1_move) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_window[i*5+j] <= r_window[i*5+j+1];
                end
                r_window[i*5+4] <= column[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: weighted row sums over the window
    // ------------------------------------------------------------------
    t_sum  row_sum [5];
    t_sum  r_row_sum [5];
    t_prod prod;
    t_coef coef;

    always_comb begin
        prod = '0;
        coef = '0;
        for (int i = 0; i < 5; i++) begin
            row_sum[i] = '0;
            for (int j = 0; j < 5; j++) begin
                coef = kern_coef(r_kernel_five, r_kernel_direction, i, j);
                prod = $signed({1'b0, r_window[i*5+j]}) * coef;
                // taps with zero weight stay out, their line rows may be unwritten
                if (coef != '0) begin
                    row_sum[i] = row_sum[i] + SUM_W'(prod);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_row_sum <= row_sum;
            r_s3_meta <= r_s2_meta;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: full kernel sum
    // ------------------------------------------------------------------
    t_sum r_sum;

    always_ff @(posedge i_clk) begin
        if (s3_move) begin
            r_sum     <= r_row_sum[0] + r_row_sum[1] + r_row_sum[2]
                       + r_row_sum[3] + r_row_sum[4];
            r_s4_meta <= r_s3_meta;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: scale, offset by 128 and clamp into the output register
    // ------------------------------------------------------------------
    t_sum   mag, biased, scaled, offs;
    t_pixel res_px;

    always_comb begin
        mag    = r_sum[SUM_W-1] ? -r_sum : r_sum;
        // 5x5: bias negative sums so the shift truncates toward zero
        biased = r_sum + (r_sum[SUM_W-1] ? t_sum'(31) : t_sum'(0));
        scaled = r_kernel_five ? (biased >>> 5) : (mag >>> 3);
        offs   = scaled + t_sum'(128);
        if (offs[SUM_W-1])             res_px = '0;
        else if (offs > t_sum'(255))   res_px = 8'd255;
        else                           res_px = t_pixel'(offs);
    end

    t_pixel r_out_px;
    t_coord r_out_col, r_out_row;
    logic   r_out_last;

    always_ff @(posedge i_clk) begin
        if (s4_move && r_s4_meta.has_res) begin
            r_out_px   <= res_px;
            r_out_col  <= r_s4_meta.col;
            r_out_row  <= r_s4_meta.row;
            r_out_last <= r_s4_meta.last;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) r_s1_valid <= in_take;
            if (s2_free) r_s2_valid <= s1_move;
            if (s3_free) r_s3_valid <= s2_move;
            if (s4_free) r_s4_valid <= s3_move;
            if (out_free) r_out_valid <= s4_move && r_s4_meta.has_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_gradient_pixel = r_out_px;
    assign o_center_col     = r_out_col;
    assign o_center_row     = r_out_row;
    assign o_last_of_frame  = r_out_last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SGWF_ASSERT_NEXT(a_cfg_restarts_frame, cfg_we && cfg_known, (r_col == '0) && (r_row == '0), "register write did not restart the frame")
    `SGWF_ASSERT_NEXT(a_s1_not_dropped, r_s1_valid && !s1_move, r_s1_valid, "stage 1 request lost while blocked")
    `SGWF_ASSERT_SAME(a_mag_offset, o_valid && !r_kernel_five, o_gradient_pixel[PIX_W-1], "3x3 result below the 128 offset")
    `SGWF_ASSERT_ALWAYS(a_col_in_frame, (r_col <= w_last) && (r_row <= h_last), "position counter outside the frame")

endmodule

// ===== tb/sobel_gradient_window_filter_tb.sv =====
// self-checking testbench of the sobel gradient window filter with its own gradient predictor
module sobel_gradient_window_filter_tb;
    import sgwf_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int RANDOM_PIXELS = 1530;
    localparam int LONG_HOLD     = 300;
    localparam int PIPE_SETTLE   = 8;     // longer than the path through the pipe registers

    // both kernel families are separable: smoothing along one axis, difference along the other
    localparam int SMOOTH3 [3] = '{1, 2, 1};
    localparam int DIFF3   [3] = '{-1, 0, 1};
    localparam int SMOOTH5 [5] = '{1, 2, 4, 2, 1};
    localparam int DIFF5   [5] = '{-1, -2, 0, 2, 1};

    typedef enum {PX_NOISE, PX_BINARY, PX_RAMP} t_px_style;

    typedef struct packed {
        t_pixel grad;
        t_coord col;
        t_coord row;
        logic   last;
    } t_grad_res;

    // dut ports
    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_pixel     i_pixel = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_pixel     o_gradient_pixel;
    t_coord     o_center_col;
    t_coord     o_center_row;
    logic       o_last_of_frame;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = REG_IMAGE_WIDTH;
    t_cfg_data  i_cfg_data = '0;

    // predictor copy of the block state
    t_pixel      line_mem [4][MAX_W];
    t_pixel      win [5][5] = '{default: '0};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned reg_width = 32'(RST_IMAGE_WIDTH);
    int unsigned reg_height = 32'(RST_IMAGE_HEIGHT);
    logic        reg_five = 1'b0;
    logic        reg_dir = 1'b0;

    t_grad_res grad_q [$];     // gradients still owed by the block, oldest first
    t_pixel    pixel_q [$];    // pixels waiting to be offered

    // handshake and pacing bookkeeping
    bit pace_on = 1'b0;
    bit hold_req = 1'b0;
    bit px_taken = 1'b0;
    bit res_taken = 1'b0;
    int px_gap = 0;
    int rx_wait = 0;
    int hold_left = 0;

    int err_cnt = 0;
    int pix_cnt = 0;
    int res_cnt = 0;
    int cfg_cnt = 0;
    int cycle_cnt = 0;

    sobel_gradient_window_filter dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned size_used(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // per-request wait of either side, 0 when the phase runs without idling
    function automatic int idle_draw();
        return pace_on ? int'($urandom_range(0, 7)) : 0;
    endfunction

    // register write as the block sees it: any write restarts the frame
    task automatic reg_apply(input t_cfg_index idx, input t_cfg_data val);
        case (idx)
            REG_IMAGE_WIDTH:      reg_width = 32'(val);
            REG_IMAGE_HEIGHT:     reg_height = 32'(val);
            REG_KERNEL_FIVE:      reg_five = val[0];
            REG_KERNEL_DIRECTION: reg_dir = val[0];
            default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    // advance the line stores and window by one pixel and queue the gradient it yields
    task automatic sobel_predict(input t_pixel px);
        int unsigned w, h, c, r, off;
        t_pixel      col_px [5];
        int          sum, res;
        bit          hit;
        t_grad_res   g;
        w = size_used(reg_width, MAX_W);
        h = size_used(reg_height, MAX_H);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        col_px[0] = line_mem[3][c];
        col_px[1] = line_mem[2][c];
        col_px[2] = line_mem[1][c];
        col_px[3] = line_mem[0][c];
        col_px[4] = px;
        line_mem[3][c] = col_px[1];
        line_mem[2][c] = col_px[2];
        line_mem[1][c] = col_px[3];
        line_mem[0][c] = px;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
            win[i][4] = col_px[i];
        end
        sum = 0;
        res = 0;
        off = 0;
        hit = 1'b0;
        if (!reg_five && r >= 2 && c >= 2) begin
            // 3x3 uses the lower right of the window, magnitude only
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    sum += int'(win[i+2][j+2]) *
                           (reg_dir ? DIFF3[i] * SMOOTH3[j] : SMOOTH3[i] * DIFF3[j]);
            if (sum < 0) sum = -sum;
            res = sum / 8 + 128;
            off = 1;
            hit = 1'b1;
        end else if (reg_five && r >= 4 && c >= 4) begin
            // signed 5x5, division truncates toward zero
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j++)
                    sum += int'(win[i][j]) *
                           (reg_dir ? DIFF5[i] * SMOOTH5[j] : SMOOTH5[i] * DIFF5[j]);
            res = sum / 32 + 128;
            if (res < 0) res = 0;
            off = 2;
            hit = 1'b1;
        end
        if (hit) begin
            if (res > 255) res = 255;
            g.grad = t_pixel'(res);
            g.col  = t_coord'(c - off);
            g.row  = t_coord'(r - off);
            g.last = (r == h - 1) && (c == w - 1);
            grad_q.push_back(g);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // pixel requests taken at the rising edge go through the predictor
    always @(posedge i_clk) begin
        px_taken = i_rst_n && i_valid && !o_stall;
        if (px_taken) begin
            sobel_predict(i_pixel);
            pix_cnt++;
        end
    end

    // pixel driver: hold while stalled, otherwise wait out the drawn gap, then offer the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || px_taken) begin
            if (px_gap > 0) begin
                i_valid <= 1'b0;
                px_gap--;
            end else if (pixel_q.size() != 0) begin
                i_valid <= 1'b1;
                i_pixel <= pixel_q.pop_front();
                px_gap = idle_draw();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver: long hold-off when asked, else a drawn stall after every result
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (res_taken) rx_wait = idle_draw();
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result monitor: each taken result against the oldest owed gradient
    always @(posedge i_clk) begin : result_check
        t_grad_res want;
        res_taken = i_rst_n && o_valid && !i_stall;
        if (res_taken) begin
            res_cnt++;
            if (grad_q.size() == 0) begin
                $error("result with none owed: gradient_pixel %0d col %0d row %0d",
                       o_gradient_pixel, o_center_col, o_center_row);
                err_cnt++;
            end else begin
                want = grad_q.pop_front();
                if (o_gradient_pixel !== want.grad) begin
                    $error("gradient_pixel: expected %0d, got %0d", want.grad, o_gradient_pixel);
                    err_cnt++;
                end
                if (o_center_col !== want.col) begin
                    $error("center_col: expected %0d, got %0d", want.col, o_center_col);
                    err_cnt++;
                end
                if (o_center_row !== want.row) begin
                    $error("center_row: expected %0d, got %0d", want.row, o_center_row);
                    err_cnt++;
                end
                if (o_last_of_frame !== want.last) begin
                    $error("last_of_frame: expected %0d, got %0d", want.last, o_last_of_frame);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d gradients still owed", cycle_cnt, grad_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic reg_write(input t_cfg_index idx, input t_cfg_data val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_apply(idx, val);
        cfg_cnt++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // all four registers; the one-bit ones carry random junk above bit 0
    task automatic set_frame(input bit five, input bit dir, input int unsigned w,
                             input int unsigned h);
        t_cfg_data junk;
        reg_write(REG_IMAGE_WIDTH, t_cfg_data'(w));
        reg_write(REG_IMAGE_HEIGHT, t_cfg_data'(h));
        junk = t_cfg_data'($urandom);
        junk[0] = five;
        reg_write(REG_KERNEL_FIVE, junk);
        junk = t_cfg_data'($urandom);
        junk[0] = dir;
        reg_write(REG_KERNEL_DIRECTION, junk);
    endtask

    task automatic queue_pixels(input int unsigned n, input t_px_style sty);
        int unsigned step;
        step = $urandom_range(1, 40);
        for (int unsigned k = 0; k < n; k++) begin
            case (sty)
                PX_NOISE:  pixel_q.push_back(t_pixel'($urandom));
                PX_BINARY: pixel_q.push_back($urandom_range(0, 1) ? 8'hff : 8'h00);
                PX_RAMP:   pixel_q.push_back(t_pixel'(k * step + $urandom_range(0, 15)));
                default:   pixel_q.push_back(8'h00);
            endcase
        end
    endtask

    // wait until every pixel is taken and every owed gradient has come back
    task automatic drain(input int settle);
        while (pixel_q.size() != 0 || i_valid || grad_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_pixel      levels [3];
        int unsigned w, h, wu, hu, n, done_px, phase;
        bit          five, dir;
        t_px_style   sty;
        levels = '{8'd0, 8'd128, 8'd255};
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sizes below 3 act as 3; hard step left to right gives the saturated magnitude
        pace_on = 1'b1;
        set_frame(1'b0, 1'b0, 0, 2);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) pixel_q.push_back(levels[c]);
        drain(PIPE_SETTLE);

        // vertical kernel, falling step top to bottom, negative sum folded to magnitude
        set_frame(1'b0, 1'b1, 3, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) pixel_q.push_back(levels[2-r]);
        drain(PIPE_SETTLE);

        // random frames: mostly small, some clamped sizes, partial and repeated frames
        phase = 0;
        done_px = 0;
        while (done_px < RANDOM_PIXELS) begin
            five = 1'($urandom_range(0, 1));
            dir  = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 15))
                0:       w = $urandom_range(0, 4);
                14, 15:  w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 15))
                0:       h = $urandom_range(0, 4);
                1:       h = $urandom_range(1025, 2047);
                default: h = $urandom_range(3, 12);
            endcase
            pace_on = ($urandom_range(0, 2) != 0);
            sty = t_px_style'($urandom_range(0, 2));
            if (phase == 2) begin
                // receiver holds off while the sender streams flat out
                five = 1'b0;
                w = 8;
                h = 8;
                pace_on = 1'b0;
            end
            wu = size_used(w, MAX_W);
            hu = size_used(h, MAX_H);
            if (hu > 64) n = wu * $urandom_range(6, 20);
            else n = wu * hu * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2 * wu);
            if (n > 400) n = 400;
            if (n > RANDOM_PIXELS - done_px) n = RANDOM_PIXELS - done_px;
            set_frame(five, dir, w, h);
            if (phase == 2) hold_req = 1'b1;
            if (phase == 4) begin
                // sender stops mid-frame until everything owed has come back
                queue_pixels(n / 2, sty);
                drain(0);
                queue_pixels(n - n / 2, sty);
            end else begin
                queue_pixels(n, sty);
            end
            drain(PIPE_SETTLE);
            done_px += n;
            phase++;
        end

        drain(20);
        $display("covered %0d pixels in %0d register writes over %0d frame setups,",
                 pix_cnt, cfg_cnt, phase + 2);
        $display("both kernel sizes and directions, clamped sizes; %0d gradients checked",
                 res_cnt);
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sgwf_pkg.sv
rtl/sobel_gradient_window_filter.sv
tb/sobel_gradient_window_filter_tb.sv
